// ----- hw/rtl/sip24_pkg.sv -----
// sip24_pkg: shared types, constants and round functions for the SipHash-2-4 MAC.
// Used by sip24_ctrl, sip24_dp, siphash_2_4_mac, sip_tag_checker and tb. No dependencies.
package sip24_pkg;

   localparam int WORD_W  = 64;
   localparam int COUNT_W = 4;
   localparam int LEN_W   = 8;
   localparam int DATA_W  = 72;   // data_word + byte_count, padded to whole bytes

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [LEN_W-1:0]   len_type;

   localparam word_type SIP_C0 = 64'h736f6d6570736575;
   localparam word_type SIP_C1 = 64'h646f72616e646f6d;
   localparam word_type SIP_C2 = 64'h6c7967656e657261;
   localparam word_type SIP_C3 = 64'h7465646279746573;
   localparam word_type FIN_FLIP = 64'h00000000000000ff;

   localparam int ROT_A = 13;
   localparam int ROT_B = 16;
   localparam int ROT_C = 21;
   localparam int ROT_D = 17;
   localparam int ROT_H = 32;

   localparam count_type FULL_COUNT = 4'd8;

   // configuration register indexes
   localparam logic REG_KEY_LOW  = 1'b0;
   localparam logic REG_KEY_HIGH = 1'b1;

   typedef struct packed {
      word_type v0;
      word_type v1;
      word_type v2;
      word_type v3;
   } lanes_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;      // take the input item, start a message if none is open
      logic round;       // one SipRound on the lanes
      logic fold;        // after the round: v0 ^= absorbed word
      logic flip;        // after the round: v2 ^= 0xff
      logic load_block;  // absorb the length-only final block
      logic emit;        // load tag register, close message
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;
      logic full;
   } status_type;

   function automatic word_type rotl(word_type x, int r);
      return (x << r) | (x >> (WORD_W - r));
   endfunction

   function automatic lanes_type sip_round(lanes_type s);
      lanes_type t;
      t = s;
      t.v0 = t.v0 + t.v1;
      t.v1 = rotl(t.v1, ROT_A) ^ t.v0;
      t.v0 = rotl(t.v0, ROT_H);
      t.v2 = t.v2 + t.v3;
      t.v3 = rotl(t.v3, ROT_B) ^ t.v2;
      t.v0 = t.v0 + t.v3;
      t.v3 = rotl(t.v3, ROT_C) ^ t.v0;
      t.v2 = t.v2 + t.v1;
      t.v1 = rotl(t.v1, ROT_D) ^ t.v2;
      t.v2 = rotl(t.v2, ROT_H);
      return t;
   endfunction

   // final block: n (< 8) message bytes with the length in the top byte
   function automatic word_type final_block(len_type len, word_type data, count_type n);
      word_type b;
      b = {len, 56'd0};
      for (int i = 0; i < 7; i++) begin
         if (COUNT_W'(i) < n) begin
            b[8*i +: 8] = data[8*i +: 8];
         end
      end
      return b;
   endfunction

endpackage

// ----- hw/rtl/sip24_ctrl.sv -----
// sip24_ctrl: sequencer for the SipHash-2-4 MAC; issues round commands to
// sip24_dp and owns the input ready and the result valid. Uses sip24_pkg.
module sip24_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  sip24_pkg::status_type status,
   output sip24_pkg::cmd_type    cmd
);
   import sip24_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001,
      ST_R1   = 8'b00000010,
      ST_R2   = 8'b00000100,
      ST_BLK  = 8'b00001000,
      ST_B1   = 8'b00010000,
      ST_B2   = 8'b00100000,
      ST_FIN  = 8'b01000000,
      ST_OUT  = 8'b10000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] fin_cnt_ff, fin_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      fin_cnt_in = fin_cnt_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_R1;
            end
         end
         ST_R1: begin
            cmd.round = 1'b1;
            state_in  = ST_R2;
         end
         ST_R2: begin
            cmd.round = 1'b1;
            cmd.fold  = 1'b1;
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (status.full) begin
               // 8-byte last word: a length-only block still follows
               state_in = ST_BLK;
            end else begin
               cmd.flip   = 1'b1;
               fin_cnt_in = '0;
               state_in   = ST_FIN;
            end
         end
         ST_BLK: begin
            cmd.load_block = 1'b1;
            state_in       = ST_B1;
         end
         ST_B1: begin
            cmd.round = 1'b1;
            state_in  = ST_B2;
         end
         ST_B2: begin
            cmd.round  = 1'b1;
            cmd.fold   = 1'b1;
            cmd.flip   = 1'b1;
            fin_cnt_in = '0;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            cmd.round  = 1'b1;
            fin_cnt_in = fin_cnt_ff + 2'd1;
            if (fin_cnt_ff == 2'd3) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fin_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_cnt_ff   <= fin_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- hw/rtl/sip24_dp.sv -----
// sip24_dp: key registers, the four chaining lanes, length count, the shared
// SipRound unit and the tag register. Driven by sip24_ctrl; uses sip24_pkg.
module sip24_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  sip24_pkg::word_type   csr_wdata,
   input  sip24_pkg::word_type   data_word,
   input  sip24_pkg::count_type  byte_count,
   input  logic                  last_word,
   input  sip24_pkg::cmd_type    cmd,
   output sip24_pkg::status_type status,
   output sip24_pkg::word_type   tag
);
   import sip24_pkg::*;

   word_type  key_low_ff, key_low_in;
   word_type  key_high_ff, key_high_in;
   lanes_type lanes_ff, lanes_in;
   word_type  word_ff, word_in;
   word_type  tag_ff, tag_in;
   len_type   len_ff, len_in;
   logic      open_ff, open_in;
   logic      last_ff, last_in;
   logic      full_ff, full_in;

   lanes_type base_lanes;
   lanes_type round_out;
   len_type   base_len;
   len_type   new_len;
   count_type sat_count;
   count_type eff_count;
   logic      eff_full;
   word_type  absorb_word;
   word_type  len_block;

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_we) begin
         case (csr_index)
            REG_KEY_LOW:  key_low_in  = csr_wdata;
            REG_KEY_HIGH: key_high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // open message: lanes and length carried on; message start: lanes from key and constants, length 0
   always_comb begin
      if (open_ff) begin
         base_lanes = lanes_ff;
         base_len   = len_ff;
      end else begin
         base_lanes.v0 = SIP_C0 ^ key_low_ff;
         base_lanes.v1 = SIP_C1 ^ key_high_ff;
         base_lanes.v2 = SIP_C2 ^ key_low_ff;
         base_lanes.v3 = SIP_C3 ^ key_high_ff;
         base_len      = '0;
      end
   end

   assign sat_count   = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
   assign eff_count   = last_word ? sat_count : FULL_COUNT;
   assign eff_full    = (eff_count == FULL_COUNT);
   assign new_len     = base_len + LEN_W'(eff_count);
   assign absorb_word = eff_full ? data_word : final_block(new_len, data_word, eff_count);
   assign len_block   = {len_ff, 56'd0};
   assign round_out   = sip_round(lanes_ff);

   always_comb begin
      lanes_in = lanes_ff;
      word_in  = word_ff;
      tag_in   = tag_ff;
      len_in   = len_ff;
      open_in  = open_ff;
      last_in  = last_ff;
      full_in  = full_ff;
      if (cmd.accept) begin
         lanes_in    = base_lanes;
         lanes_in.v3 = base_lanes.v3 ^ absorb_word;
         word_in     = absorb_word;
         len_in      = new_len;
         open_in     = 1'b1;
         last_in     = last_word;
         full_in     = eff_full;
      end
      if (cmd.load_block) begin
         lanes_in.v3 = lanes_ff.v3 ^ len_block;
         word_in     = len_block;
      end
      if (cmd.round) begin
         lanes_in = round_out;
         if (cmd.fold) begin
            lanes_in.v0 = round_out.v0 ^ word_ff;
         end
         if (cmd.flip) begin
            lanes_in.v2 = round_out.v2 ^ FIN_FLIP;
         end
      end
      if (cmd.emit) begin
         tag_in  = lanes_ff.v0 ^ lanes_ff.v1 ^ lanes_ff.v2 ^ lanes_ff.v3;
         open_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         len_ff      <= '0;
         open_ff     <= 1'b0;
         last_ff     <= 1'b0;
         full_ff     <= 1'b0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         len_ff      <= len_in;
         open_ff     <= open_in;
         last_ff     <= last_in;
         full_ff     <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
      word_ff  <= word_in;
      tag_ff   <= tag_in;
   end

   assign status.last = last_ff;
   assign status.full = full_ff;
   assign tag         = tag_ff;

endmodule

// ----- hw/rtl/siphash_2_4_mac.sv -----
// siphash_2_4_mac: SipHash-2-4 keyed 64-bit tag over a little-endian word stream.
// Top level; instantiates sip24_ctrl and sip24_dp, uses sip24_pkg.
//
//   group | dir | transfer      | payload
//   ------+-----+---------------+----------------------------------------------
//   req_  | in  | tvalid&tready | tdata: data_word, byte_count; tlast: last_word
//   rsp_  | out | tvalid&tready | tdata: tag
//   csr_  | in  | we            | index 0 key_low, 1 key_high; wdata
//
// A non-last word is accepted and given two rounds; a last word with 0..7 bytes
// then gets the finalization rounds before the tag, one with 8 bytes a length-only
// block first. All rounds run one per cycle through the single SipRound unit in sip24_dp.
// Reset is synchronous; keys clear to zero and no message is open.
// The tag sits in an output register; the block goes back to taking words
// while it waits, and a following tag is held until the previous is taken.
module siphash_2_4_mac (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sip24_pkg::DATA_W-1:0]    req_tdata,   // [63:0] data_word, [67:64] byte_count
   input  logic                            req_tlast,   // last_word
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sip24_pkg::WORD_W-1:0]    rsp_tdata,   // [63:0] tag
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [sip24_pkg::WORD_W-1:0]    csr_wdata
);
   import sip24_pkg::*;

   cmd_type    cmd;
   status_type status;

   sip24_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sip24_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .data_word  (req_tdata[WORD_W-1:0]),
      .byte_count (req_tdata[WORD_W +: COUNT_W]),
      .last_word  (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .tag        (rsp_tdata)
   );

endmodule

// ----- hw/rtl/sip24_chk.sv -----
// sip24_chk: port-level checks for siphash_2_4_mac, attached by bind below.
// Depends on the top level's port names only.
module sip24_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // a stalled tag holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("tag changed or dropped while stalled");

   // one word at a time: busy the cycle after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a transfer");

   // a tag never shows up directly after a word is taken
   a_no_early_tag: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("tag appeared too early");

   // a new tag is only posted while the input side is busy
   a_tag_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("tag posted while idle");

endmodule

bind siphash_2_4_mac sip24_chk u_chk (.*);

// ----- tb/sv/sip_tag_checker.sv -----
`timescale 1ns / 1ps
// sip_tag_checker: watches the request, response and key-register ports of siphash_2_4_mac,
// predicts every SipHash-2-4 tag and compares it with the response stream.
// Depends on sip24_pkg for widths, lane type, rotation amounts and register indexes.
module sip_tag_checker
   import sip24_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,   // [63:0] data_word, [67:64] byte_count
   input  logic                req_tlast,   // last_word
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [WORD_W-1:0]   rsp_tdata,   // [63:0] tag
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [WORD_W-1:0]   csr_wdata,
   output int unsigned         fail_count,
   output int unsigned         tags_pending
);

   word_type    key_lo = '0;
   word_type    key_hi = '0;
   lanes_type   lanes = '0;
   len_type     msg_len = '0;
   logic        msg_open = 1'b0;
   word_type    tags_due[$];
   int unsigned errs = 0;

   function automatic word_type rot_left(word_type x, int unsigned amt);
      return (x << amt) | (x >> (WORD_W - amt));
   endfunction

   function automatic lanes_type sip_mix(lanes_type s);
      s.v0 = s.v0 + s.v1;
      s.v1 = rot_left(s.v1, ROT_A) ^ s.v0;
      s.v0 = rot_left(s.v0, ROT_H);
      s.v2 = s.v2 + s.v3;
      s.v3 = rot_left(s.v3, ROT_B) ^ s.v2;
      s.v0 = s.v0 + s.v3;
      s.v3 = rot_left(s.v3, ROT_C) ^ s.v0;
      s.v2 = s.v2 + s.v1;
      s.v1 = rot_left(s.v1, ROT_D) ^ s.v2;
      s.v2 = rot_left(s.v2, ROT_H);
      return s;
   endfunction

   // compression: two rounds between the xor-in and the xor-out
   function automatic lanes_type absorb_word(lanes_type s, word_type w);
      s.v3 = s.v3 ^ w;
      s = sip_mix(sip_mix(s));
      s.v0 = s.v0 ^ w;
      return s;
   endfunction

   always @(posedge clock) begin
      word_type  data;
      word_type  block;
      word_type  want;
      count_type cnt;
      if (reset) begin
         key_lo   = '0;
         key_hi   = '0;
         lanes    = '0;
         msg_len  = '0;
         msg_open = 1'b0;
         tags_due.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_KEY_LOW) key_lo = csr_wdata;
            else                          key_hi = csr_wdata;
         end

         if (req_tvalid && req_tready) begin
            data = req_tdata[WORD_W-1:0];
            cnt  = req_tdata[WORD_W +: COUNT_W];
            // key is captured only when a message opens
            if (!msg_open) begin
               lanes.v0 = SIP_C0 ^ key_lo;
               lanes.v1 = SIP_C1 ^ key_hi;
               lanes.v2 = SIP_C2 ^ key_lo;
               lanes.v3 = SIP_C3 ^ key_hi;
               msg_len  = '0;
               msg_open = 1'b1;
            end
            if (cnt > FULL_COUNT || !req_tlast) cnt = FULL_COUNT;
            msg_len = msg_len + len_type'(cnt);
            if (cnt == FULL_COUNT) lanes = absorb_word(lanes, data);
            if (req_tlast) begin
               block = {msg_len, 56'd0};
               if (cnt != FULL_COUNT) begin
                  for (int i = 0; i < 8; i++) begin
                     if (i < int'(cnt)) block[8*i +: 8] = data[8*i +: 8];
                  end
               end
               lanes    = absorb_word(lanes, block);
               lanes.v2 = lanes.v2 ^ FIN_FLIP;
               for (int r = 0; r < 4; r++) lanes = sip_mix(lanes);
               tags_due.push_back(lanes.v0 ^ lanes.v1 ^ lanes.v2 ^ lanes.v3);
               msg_open = 1'b0;
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            if (tags_due.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("%0t: tag %h with no message closed", $realtime, rsp_tdata);
            end else begin
               want = tags_due.pop_front();
               if (rsp_tdata !== want) begin
                  errs++;
                  if (errs <= 10)
                     $display("%0t: tag mismatch, expected %h, got %h",
                              $realtime, want, rsp_tdata);
               end
            end
         end
      end
      fail_count   <= errs;
      tags_pending <= tags_due.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// tb: stimulus and verdict for siphash_2_4_mac; streams messages under several keys and
// idle/stall mixes. Depends on sip24_pkg, siphash_2_4_mac and sip_tag_checker.
module tb;
   import sip24_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata = '0;   // [63:0] data_word, [67:64] byte_count
   logic                req_tlast = 1'b0; // last_word
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [WORD_W-1:0]   rsp_tdata;        // [63:0] tag
   logic                csr_we = 1'b0;
   logic                csr_index = REG_KEY_LOW;
   logic [WORD_W-1:0]   csr_wdata = '0;

   int unsigned fail_count;
   int unsigned tags_pending;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic        hold_go = 1'b0;
   logic        hold_seen = 1'b0;
   int unsigned hold_left = 0;
   int unsigned items_sent = 0;

   siphash_2_4_mac dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sip_tag_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .tags_pending (tags_pending)
   );

   always #5 clock = ~clock;

   initial begin
      #3_000_000;
      $display("tb: done, errors");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off whenever hold_go toggles
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_go != hold_seen) begin
         hold_seen = hold_go;
         hold_left = 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // called at a rising edge; returns at the edge of the transfer
   task automatic send_item(input word_type data, input count_type cnt, input logic last);
      logic ready_seen;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(DATA_W-WORD_W-COUNT_W){1'b0}}, cnt, data};
      req_tlast  <= last;
      forever begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
         if (ready_seen) break;
      end
      items_sent++;
   endtask

   task automatic write_keys(input word_type lo, input word_type hi);
      csr_we    <= 1'b1;
      csr_index <= REG_KEY_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= REG_KEY_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // drain all tags, then give the round unit time to finish a non-last word
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (tags_pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_message(input int unsigned nwords);
      count_type cnt;
      for (int unsigned i = 1; i <= nwords; i++) begin
         if (i < nwords)
            cnt = ($urandom_range(9) == 0) ? count_type'($urandom_range(15)) : FULL_COUNT;
         else if ($urandom_range(9) == 0)
            cnt = count_type'($urandom_range(15, 9));
         else
            cnt = count_type'($urandom_range(8));
         send_item({$urandom, $urandom}, cnt, i == nwords);
      end
   endtask

   initial begin
      word_type    phase_lo[4];
      word_type    phase_hi[4];
      int unsigned goal;

      phase_lo[0] = 64'h0706050403020100;
      phase_hi[0] = 64'h0f0e0d0c0b0a0908;
      phase_lo[1] = '1;
      phase_hi[1] = '1;
      phase_lo[2] = {$urandom, $urandom};
      phase_hi[2] = {$urandom, $urandom};
      phase_lo[3] = '0;
      phase_hi[3] = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message under the reset key
      send_item('0, 4'd0, 1'b1);
      wait_quiet();
      write_keys(phase_lo[0], phase_hi[0]);
      // single short last words, upper bytes must be ignored
      for (int n = 1; n < 8; n++) send_item(64'hffeeddcc_0302_0100, count_type'(n), 1'b1);
      send_item('1, FULL_COUNT, 1'b1);
      send_item('0, 4'd15, 1'b1);         // saturated count
      send_item('1, 4'd9, 1'b1);
      send_item('1, FULL_COUNT, 1'b0);
      send_item('0, 4'd0, 1'b1);
      // non-last words with odd counts count as full words
      send_item(64'h0123456789abcdef, 4'd0, 1'b0);
      send_item('1, 4'd15, 1'b0);
      send_item(64'h8000000000000001, 4'd5, 1'b1);
      // key change in the middle of a message applies from the next one
      send_item(64'hdeadbeefcafef00d, FULL_COUNT, 1'b0);
      wait_quiet();
      write_keys(phase_lo[1], phase_hi[1]);
      send_item(64'h5555aaaa5555aaaa, 4'd2, 1'b1);
      send_item('0, 4'd0, 1'b1);
      wait_quiet();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct <= 46; recv_stall_pct <= 0;  end
            2: begin send_idle_pct <= 0;  recv_stall_pct <= 46; end
            default: begin send_idle_pct <= 26; recv_stall_pct <= 26; end
         endcase
         write_keys(phase_lo[p], phase_hi[p]);
         if (p == 0) begin
            // long receiver hold-off with the sender running flat out
            hold_go <= ~hold_go;
            for (int m = 0; m < 10; m++) send_message($urandom_range(2, 1));
         end
         goal = items_sent + 350;
         while (items_sent < goal) begin
            if ($urandom_range(19) == 0) send_message($urandom_range(40, 32));
            else                         send_message($urandom_range(6, 1));
         end
         wait_quiet();
      end

      if (fail_count == 0) $display("tb: done, clean");
      else                 $display("tb: done, errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/sip24_pkg.sv
hw/rtl/sip24_ctrl.sv
hw/rtl/sip24_dp.sv
hw/rtl/siphash_2_4_mac.sv
hw/rtl/sip24_chk.sv
tb/sv/sip_tag_checker.sv
tb/sv/tb.sv
